// ===== rtl/core/owm_pkg.sv =====
// omni wheel mixer shared package: widths, register indexes and trig tables
// no dependencies
package owm_pkg;

    localparam int MAX_WHEELS_DEF = 8;
    localparam int TBL_ROWS       = 8;
    localparam int CMD_W          = 16;
    localparam int COEF_W         = 16;
    localparam int RAW_W          = 35;
    localparam int LIM_W          = 15;
    localparam int PROD_W         = 50;
    localparam int DRV_W          = 16;
    localparam int IDX_W          = 3;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [CMD_W-1:0] x;
        logic signed [CMD_W-1:0] y;
        logic signed [CMD_W-1:0] turn;
        logic [IDX_W-1:0]        row;
    } t_cmd;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic [RAW_W-1:0]        norm;
        logic [LIM_W-1:0]        limit;
    } t_job;

    function automatic logic signed [COEF_W-1:0] cos_q14(
        input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        logic signed [COEF_W-1:0] v;
        v = '0;
        unique case ({row, col})
            6'o00: v = -16'sd16384;
            6'o20: v = 16'sd8192;  6'o21: v = -16'sd16384; 6'o22: v = 16'sd8192;
            6'o30: v = 16'sd11585; 6'o31: v = -16'sd11585;
            6'o32: v = -16'sd11585; 6'o33: v = 16'sd11585;
            6'o40: v = 16'sd13255; 6'o41: v = -16'sd5063; 6'o42: v = -16'sd16384;
            6'o43: v = -16'sd5063; 6'o44: v = 16'sd13255;
            6'o50: v = 16'sd14189; 6'o52: v = -16'sd14189; 6'o53: v = -16'sd14189;
            6'o55: v = 16'sd14189;
            6'o60: v = 16'sd14761; 6'o61: v = 16'sd3646; 6'o62: v = -16'sd10215;
            6'o63: v = -16'sd16384; 6'o64: v = -16'sd10215; 6'o65: v = 16'sd3646;
            6'o66: v = 16'sd14761;
            6'o70: v = 16'sd15137; 6'o71: v = 16'sd6270; 6'o72: v = -16'sd6270;
            6'o73: v = -16'sd15137; 6'o74: v = -16'sd15137; 6'o75: v = -16'sd6270;
            6'o76: v = 16'sd6270; 6'o77: v = 16'sd15137;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] sin_q14(
        input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        logic signed [COEF_W-1:0] v;
        v = '0;
        unique case ({row, col})
            6'o10: v = 16'sd16384; 6'o11: v = -16'sd16384;
            6'o20: v = 16'sd14189; 6'o22: v = -16'sd14189;
            6'o30: v = 16'sd11585; 6'o31: v = 16'sd11585;
            6'o32: v = -16'sd11585; 6'o33: v = -16'sd11585;
            6'o40: v = 16'sd9630; 6'o41: v = 16'sd15582; 6'o43: v = -16'sd15582;
            6'o44: v = -16'sd9630;
            6'o50: v = 16'sd8192; 6'o51: v = 16'sd16384; 6'o52: v = 16'sd8192;
            6'o53: v = -16'sd8192; 6'o54: v = -16'sd16384; 6'o55: v = -16'sd8192;
            6'o60: v = 16'sd7109; 6'o61: v = 16'sd15973; 6'o62: v = 16'sd12810;
            6'o64: v = -16'sd12810; 6'o65: v = -16'sd15973; 6'o66: v = -16'sd7109;
            6'o70: v = 16'sd6270; 6'o71: v = 16'sd15137; 6'o72: v = 16'sd15137;
            6'o73: v = 16'sd6270; 6'o74: v = -16'sd6270; 6'o75: v = -16'sd15137;
            6'o76: v = -16'sd15137; 6'o77: v = -16'sd6270;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/omni_wheel_mixer_unit.sv =====
// Omni wheel mixer: each accepted command (x, y, turn) gives one result per
// wheel, wheel 0 first, tlast on the final one. The front end makes one pass
// over the wheels for the normalizer and a second pass issuing jobs; the back
// end handles one job at a time (load, multiply, 16-step divide, output) and
// takes no new job until its result is in the output register, so sustained
// throughput is set by that divider. A two-entry queue separates the two
// halves. Config writes are taken any time but must only be issued while idle.
module omni_wheel_mixer_unit import owm_pkg::*; #(
    parameter int MAX_WHEELS = MAX_WHEELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,   // x_command, y_command, turn_command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // wheel_index, drive_value, zero fill
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [CNT_W-1:0] r_count;
    logic [LIM_W-1:0] r_limit;
    t_cmd             cmd;
    t_job             fj, qj;
    logic             fv, fr, qv, qr;
    logic [IDX_W-1:0] idx;
    logic [DRV_W-1:0] drv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(4);
            r_limit <= LIM_W'(16384);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WHEEL_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                REG_POWER_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cmd = '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                   turn: s_axis_tdata[47:32], row: '0};

    owm_front #(.MAX_WHEELS(MAX_WHEELS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(cmd), .i_count(r_count), .i_limit(r_limit),
        .o_job_valid(fv), .i_job_ready(fr), .o_job(fj));

    owm_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fv), .o_ready(fr), .i_job(fj),
        .o_valid(qv), .i_ready(qr), .o_job(qj));

    owm_scale u_scale (
        .i_clk, .i_rst_n, .i_valid(qv), .o_ready(qr), .i_job(qj),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_idx(idx), .o_drive(drv), .o_last(m_axis_tlast));

    assign m_axis_tdata = {5'd0, drv, idx};
endmodule

// ===== rtl/core/owm_front.sv =====
// front end: takes commands, walks the wheels computing raw values and the normalizer
// depends on owm_pkg; feeds jobs into the queue one wheel at a time
module owm_front import owm_pkg::*; #(
    parameter int MAX_WHEELS = MAX_WHEELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_cmd                  i_cmd,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [LIM_W-1:0]      i_limit,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job                  o_job
);
    // pass 0 finds the normalizer, pass 1 emits jobs
    logic              r_busy, n_busy;
    logic              r_pass, n_pass;
    logic [IDX_W-1:0]  r_col, n_col;
    t_cmd              r_cmd;
    logic [RAW_W-1:0]  r_norm;
    logic [LIM_W-1:0]  r_limit;

    logic signed [RAW_W-1:0] raw;
    logic [RAW_W-1:0]        mag;
    logic                    col_last, step;

    assign raw = RAW_W'(r_cmd.x * cos_q14(r_cmd.row, r_col))
               + RAW_W'(r_cmd.y * sin_q14(r_cmd.row, r_col))
               + (RAW_W'(r_cmd.turn) <<< 14);
    assign mag      = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
    assign col_last = (r_col == r_cmd.row);
    assign step     = r_busy && (!r_pass || i_job_ready);

    assign o_ready     = !r_busy || (r_pass && col_last && i_job_ready);
    assign o_job_valid = r_busy && r_pass;
    assign o_job       = '{raw: raw, idx: r_col, last: col_last,
                           norm: r_norm, limit: r_limit};

    always_comb begin
        n_busy = r_busy;
        n_pass = r_pass;
        n_col  = r_col;
        if (step) begin
            if (col_last) begin
                n_col  = '0;
                n_pass = !r_pass;
                if (r_pass) n_busy = 1'b0;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_valid && o_ready && i_count != '0) begin
            n_busy = 1'b1;
            n_pass = 1'b0;
            n_col  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_col  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pass <= n_pass;
            r_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd   <= '{x: i_cmd.x, y: i_cmd.y, turn: i_cmd.turn,
                         row: (i_count > CNT_W'(MAX_WHEELS)) ? IDX_W'(MAX_WHEELS - 1)
                                                              : IDX_W'(i_count - 1'b1)};
            r_norm  <= RAW_W'(1) << 26;
            r_limit <= i_limit;
        end else if (step && !r_pass && mag > r_norm) begin
            r_norm <= mag;
        end
    end
endmodule

// ===== rtl/core/owm_queue.sv =====
// two-entry job queue between the front end and the scaler
// depends on owm_pkg
module owm_queue import owm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

// ===== rtl/core/owm_scale.sv =====
// back end: raw*limit then a restoring divide by the normalizer, one bit a cycle
// depends on owm_pkg; output register holds the finished result
module owm_scale import owm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_job                    i_job,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [IDX_W-1:0]        o_idx,
    output logic signed [DRV_W-1:0] o_drive,
    output logic                    o_last
);
    localparam int QB = 16;   // quotient magnitude < 2^15, 16 steps is ample

    logic              r_busy, r_mul;
    logic [4:0]        r_cnt;
    logic [PROD_W-1:0] r_rem;
    logic [RAW_W-1:0]  r_den;
    logic [QB-1:0]     r_q;
    logic              r_neg;
    logic [IDX_W-1:0]  r_idx;
    logic              r_last;
    logic [RAW_W-1:0]  r_mag;
    logic [LIM_W-1:0]  r_lim;
    logic              r_ovalid, n_ovalid;

    logic              done, take, fire;
    logic [PROD_W-1:0] trial;
    logic [PROD_W-1:0] rem_sh;

    assign done    = r_busy && !r_mul && r_cnt == 5'd0;
    assign fire    = done && (!r_ovalid || i_ready);
    assign o_ready = !r_busy;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ovalid;

    // numerator < 2^(QB-1) * den, so start with den shifted left by QB-1
    assign rem_sh = r_rem;
    assign trial  = (PROD_W'(r_den) << (r_cnt - 5'd1));

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        if (fire) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_mul    <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (take) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
            end else if (r_mul) begin
                r_mul <= 1'b0;
                r_cnt <= 5'(QB);
            end else if (r_busy && r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mag  <= i_job.raw[RAW_W-1] ? RAW_W'(-i_job.raw) : RAW_W'(i_job.raw);
            r_neg  <= i_job.raw[RAW_W-1];
            r_den  <= i_job.norm;
            r_lim  <= i_job.limit;
            r_idx  <= i_job.idx;
            r_last <= i_job.last;
        end else if (r_mul) begin
            r_rem <= PROD_W'(r_mag * r_lim);
            r_q   <= '0;
        end else if (r_busy && r_cnt != 5'd0) begin
            if (rem_sh >= trial) begin
                r_rem <= rem_sh - trial;
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
        if (fire) begin
            o_drive <= r_neg ? DRV_W'(-r_q) : DRV_W'(r_q);
            o_idx   <= r_idx;
            o_last  <= r_last;
        end
    end
endmodule

// ===== rtl/core/owm_checker.sv =====
// port-level checker for the omni wheel mixer, bound to the top level
// depends only on the top level ports
module owm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
        else $error("pad bits set");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |->
        m_axis_tdata[2:0] != 3'd7)
        else $error("wheel index past last");
endmodule

bind omni_wheel_mixer_unit owm_checker u_owm_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast);

// ===== dv/tb_omni_wheel_mixer_unit.sv =====
// testbench for omni_wheel_mixer_unit: random and directed motion commands,
// per-wheel drive values checked against an in-bench kinematics predictor
// depends on owm_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_omni_wheel_mixer_unit import owm_pkg::*;;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] turn;
    } t_motion;

    typedef struct {
        logic [2:0]         wheel;
        logic signed [15:0] drive;
        logic               last;
    } t_drive;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_WHEEL_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_motion pending_cmds[$];
    t_drive  expected_drives[$];
    int      error_count = 0;
    int      sent_count = 0;
    int      queued_count = 0;
    bit      calm = 1'b0;
    bit      hold_send = 1'b0;
    logic [3:0]  cur_wheels;
    logic [14:0] cur_limit;

    omni_wheel_mixer_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // per-wheel trig constants, Q1.14
    function automatic int cos_tab(int row, int col);
        int t[8][8] = '{
            '{-16384, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{8192, -16384, 8192, 0, 0, 0, 0, 0},
            '{11585, -11585, -11585, 11585, 0, 0, 0, 0},
            '{13255, -5063, -16384, -5063, 13255, 0, 0, 0},
            '{14189, 0, -14189, -14189, 0, 14189, 0, 0},
            '{14761, 3646, -10215, -16384, -10215, 3646, 14761, 0},
            '{15137, 6270, -6270, -15137, -15137, -6270, 6270, 15137}};
        return t[row][col];
    endfunction

    function automatic int sin_tab(int row, int col);
        int t[8][8] = '{
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{16384, -16384, 0, 0, 0, 0, 0, 0},
            '{14189, 0, -14189, 0, 0, 0, 0, 0},
            '{11585, 11585, -11585, -11585, 0, 0, 0, 0},
            '{9630, 15582, 0, -15582, -9630, 0, 0, 0},
            '{8192, 16384, 8192, -8192, -16384, -8192, 0, 0},
            '{7109, 15973, 12810, 0, -12810, -15973, -7109, 0},
            '{6270, 15137, 15137, 6270, -6270, -15137, -15137, -6270}};
        return t[row][col];
    endfunction

    task automatic predict_wheel_drives(t_motion c);
        longint raw[8];
        longint norm;
        longint a;
        longint q;
        int n;
        t_drive d;
        norm = longint'(1) << 26;
        n = (cur_wheels > 8) ? 8 : int'(cur_wheels);
        for (int i = 0; i < n; i++) begin
            raw[i] = longint'(c.x) * cos_tab(n - 1, i) + longint'(c.y) * sin_tab(n - 1, i)
                     + longint'(c.turn) * 16384;
            a = raw[i] < 0 ? -raw[i] : raw[i];
            if (a > norm) norm = a;
        end
        for (int i = 0; i < n; i++) begin
            q = (raw[i] * longint'(cur_limit)) / norm;
            d.wheel = i[2:0];
            d.drive = q[15:0];
            d.last  = (i == n - 1);
            expected_drives.push_back(d);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // driver: predicts at acceptance so config changes line up
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_wheel_drives(pending_cmds.pop_front());
            sent_count++;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if ((!s_axis_tvalid || s_axis_tready)) begin
            // head of the queue is the next transaction to offer
            if (!hold_send && pending_cmds.size() > 0 &&
                (calm || $urandom_range(99) >= 21)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pending_cmds[0].turn, pending_cmds[0].y, pending_cmds[0].x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_drive e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch("drive value with none expected");
                end else begin
                    e = expected_drives.pop_front();
                    if (m_axis_tdata[2:0] !== e.wheel)
                        report_mismatch($sformatf("wheel got %0d exp %0d",
                                                  m_axis_tdata[2:0], e.wheel));
                    if ($signed(m_axis_tdata[18:3]) !== e.drive)
                        report_mismatch($sformatf("wheel %0d drive got %0d exp %0d", e.wheel,
                                                  $signed(m_axis_tdata[18:3]), e.drive));
                    if (m_axis_tdata[23:19] !== 5'd0)
                        report_mismatch("fill bits not zero");
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("wheel %0d last got %0b exp %0b", e.wheel,
                                                  m_axis_tlast, e.last));
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    task automatic add_cmd(int x, int y, int t);
        t_motion c;
        c.x = x[15:0];
        c.y = y[15:0];
        c.turn = t[15:0];
        pending_cmds.push_back(c);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (sent_count != queued_count || expected_drives.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[14:0];
        if (idx == REG_WHEEL_COUNT) cur_wheels = val[3:0];
        else cur_limit = val[14:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_random(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(9);
            if (r < 2)
                add_cmd($urandom_range(255) - 128, $urandom_range(255) - 128,
                        $urandom_range(63) - 32);
            else
                add_cmd($urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int wsets[8] = '{8, 1, 0, 15, 3, 6, 5, 2};
        int lsets[8] = '{0, 32767, 16384, 1, 8192, 20000, 12345, 16384};
        cur_wheels = 4;
        cur_limit  = 15'd16384;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset config, field extremes
        add_cmd(0, 0, 0);
        add_cmd(32767, 32767, 32767);
        add_cmd(-32768, -32768, -32768);
        add_cmd(32767, -32768, 0);
        add_cmd(0, 0, -32768);
        add_cmd(4096, 0, 0);
        add_cmd(1, -1, 1);
        add_cmd(-21846, 21845, -1);
        wait_drained();
        // directed over wheel counts, zero wheels and saturated count included
        for (int w = 0; w <= 15; w += (w < 9) ? 1 : 6) begin
            write_reg(REG_WHEEL_COUNT, w);
            add_cmd(-32768, 32767, 12000);
            wait_drained();
        end
        // random phases under several settings
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_WHEEL_COUNT, wsets[p]);
            write_reg(REG_POWER_LIMIT, lsets[p]);
            calm = (p == 2);
            add_random(17);
            wait_drained();
        end
        calm = 1'b0;
        // sender holds off while the commands are queued, then releases and drains
        add_random(4);
        hold_send = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_send = 1'b0;
        wait_drained();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/owm_pkg.sv
rtl/core/owm_front.sv
rtl/core/owm_queue.sv
rtl/core/owm_scale.sv
rtl/core/omni_wheel_mixer_unit.sv
rtl/core/owm_checker.sv
dv/tb_omni_wheel_mixer_unit.sv
